/* hw/rtl/pfa_pkg.sv */
// Shared types and constants for the page frame allocator.
// Used by the allocator core, the top level and the testbench.
`default_nettype none

package pfa_pkg;

    // Frame space
    localparam int MAX_FRAMES = 256;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = FRAME_W + 1;

    // Field widths
    localparam int PID_W    = 32;
    localparam int PAGE_W   = 52;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 9;

    // Stream packing
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [CNT_W-1:0]   t_count;

    // Request kind
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STATUS_OK           = 2'd0;
    localparam t_status STATUS_FULL         = 2'd1;
    localparam t_status STATUS_NOT_RESIDENT = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // One write port of a frame-wide RAM
    typedef struct packed {
        logic   en;
        t_frame addr;
        t_frame data;
    } t_ram_wr;

    // One read port of a frame-wide RAM
    typedef struct packed {
        logic   en;
        t_frame addr;
    } t_ram_rd;

endpackage

`default_nettype wire

/* hw/rtl/pfa_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle.
// Holds link pointers and the free-frame ring; no dependencies.
`default_nettype none

module pfa_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pfa_core.sv */
// Allocator control: request sequencing, list head/tail/hand, free-ring
// pointers, residency bits and result register. Uses pfa_pkg.
`default_nettype none

module pfa_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Capacity register write
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [pfa_pkg::CAP_W-1:0] i_cfg_data,
    // Request
    input  wire logic                  i_req_valid,
    output logic                       o_req_ready,
    input  wire logic                  i_req_op,
    input  wire pfa_pkg::t_frame       i_req_frame,
    // Result
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output pfa_pkg::t_status           o_res_status,
    output pfa_pkg::t_frame            o_res_granted,
    output pfa_pkg::t_frame            o_res_hand,
    output logic                       o_res_hand_valid,
    output pfa_pkg::t_count            o_res_count,
    // Link and ring RAM ports
    output pfa_pkg::t_ram_rd           o_link_rd,
    input  wire pfa_pkg::t_frame       i_next_rdata,
    input  wire pfa_pkg::t_frame       i_prev_rdata,
    output pfa_pkg::t_ram_wr           o_next_wr,
    output pfa_pkg::t_ram_wr           o_prev_wr,
    output pfa_pkg::t_ram_rd           o_ring_rd,
    input  wire pfa_pkg::t_frame       i_ring_rdata,
    output pfa_pkg::t_ram_wr           o_ring_wr
);

    import pfa_pkg::*;

    t_state r_state, n_state;

    logic   r_op;
    t_frame r_frame;
    logic   r_resident;
    logic [CAP_W-1:0] r_cap;

    t_frame r_rp, n_rp;
    t_frame r_wp, n_wp;
    t_count r_free_cnt, n_free_cnt;
    t_count r_bump, n_bump;
    t_frame r_head, n_head;
    t_frame r_tail, n_tail;
    t_frame r_hand, n_hand;
    t_count r_size, n_size;

    logic [MAX_FRAMES-1:0] r_mask;
    logic   n_mask_set, n_mask_clr;
    t_frame n_mask_idx;

    logic    r_out_valid;
    t_status r_status, n_status;
    t_frame  r_granted, n_granted;
    t_frame  r_hand_out;
    logic    r_hand_vld;
    t_count  r_count;

    logic   accept;
    logic   done;
    t_count limit;
    t_frame alloc_f;
    logic   has_prev, has_next;

    assign o_cfg_ready = 1'b1;
    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign done        = (r_state == ST_EXEC) && (!r_out_valid || i_res_ready);

    // Issue memory reads with the request transfer
    assign o_link_rd = '{en: accept, addr: i_req_frame};
    assign o_ring_rd = '{en: accept, addr: r_rp};

    // Bump limit is the capacity clipped to the frame space
    assign limit = (r_cap < CAP_W'(MAX_FRAMES)) ? t_count'(r_cap) : t_count'(MAX_FRAMES);
    assign alloc_f  = (r_free_cnt != '0) ? i_ring_rdata : r_bump[FRAME_W-1:0];
    assign has_prev = (r_frame != r_head);
    assign has_next = (r_frame != r_tail);

    // Next state, list update and RAM writes
    always_comb begin
        n_state    = r_state;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_free_cnt = r_free_cnt;
        n_bump     = r_bump;
        n_head     = r_head;
        n_tail     = r_tail;
        n_hand     = r_hand;
        n_size     = r_size;
        n_mask_set = 1'b0;
        n_mask_clr = 1'b0;
        n_mask_idx = r_frame;
        n_status   = STATUS_OK;
        n_granted  = '0;
        o_next_wr  = '0;
        o_prev_wr  = '0;
        o_ring_wr  = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    n_state = ST_IDLE;
                    if (r_op == OP_ALLOC) begin
                        if ((r_free_cnt != '0) || (r_bump < limit)) begin
                            // Take from the ring first, else from the bump counter
                            if (r_free_cnt != '0) begin
                                n_rp       = r_rp + 1'b1;
                                n_free_cnt = r_free_cnt - 1'b1;
                            end else begin
                                n_bump = r_bump + 1'b1;
                            end
                            n_mask_set = 1'b1;
                            n_mask_idx = alloc_f;
                            n_granted  = alloc_f;
                            // Append at the tail
                            if (r_size != '0) begin
                                o_next_wr = '{en: 1'b1, addr: r_tail, data: alloc_f};
                                o_prev_wr = '{en: 1'b1, addr: alloc_f, data: r_tail};
                            end else begin
                                n_head = alloc_f;
                                n_hand = alloc_f;
                            end
                            n_tail = alloc_f;
                            n_size = r_size + 1'b1;
                        end else begin
                            n_status = STATUS_FULL;
                        end
                    end else begin
                        if (r_resident) begin
                            // Unlink the frame and move the hand off it
                            if (!has_prev && !has_next) begin
                                n_head = '0;
                                n_tail = '0;
                                n_hand = '0;
                            end else if (!has_prev) begin
                                if (r_hand == r_frame) begin
                                    n_hand = i_next_rdata;
                                end
                                n_head = i_next_rdata;
                            end else if (!has_next) begin
                                if (r_hand == r_frame) begin
                                    n_hand = r_head;
                                end
                                n_tail = i_prev_rdata;
                            end else begin
                                if (r_hand == r_frame) begin
                                    n_hand = i_next_rdata;
                                end
                                o_next_wr = '{en: 1'b1, addr: i_prev_rdata, data: i_next_rdata};
                                o_prev_wr = '{en: 1'b1, addr: i_next_rdata, data: i_prev_rdata};
                            end
                            if (r_size != '0) begin
                                n_size = r_size - 1'b1;
                            end
                            n_mask_clr = 1'b1;
                            // Push onto the free ring
                            if (r_free_cnt < t_count'(MAX_FRAMES)) begin
                                o_ring_wr  = '{en: 1'b1, addr: r_wp, data: r_frame};
                                n_wp       = r_wp + 1'b1;
                                n_free_cnt = r_free_cnt + 1'b1;
                            end
                        end else begin
                            n_status = STATUS_NOT_RESIDENT;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cap      <= CAP_RESET;
            r_rp       <= '0;
            r_wp       <= '0;
            r_free_cnt <= '0;
            r_bump     <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_hand     <= '0;
            r_size     <= '0;
        end else begin
            r_state    <= n_state;
            r_rp       <= n_rp;
            r_wp       <= n_wp;
            r_free_cnt <= n_free_cnt;
            r_bump     <= n_bump;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_hand     <= n_hand;
            r_size     <= n_size;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Residency bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (n_mask_set) begin
            r_mask[n_mask_idx] <= 1'b1;
        end else if (n_mask_clr) begin
            r_mask[n_mask_idx] <= 1'b0;
        end
    end

    // Hold the request payload and its residency bit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_req_op;
            r_frame    <= i_req_frame;
            r_resident <= r_mask[i_req_frame];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_status   <= n_status;
            r_granted  <= n_granted;
            r_hand_out <= (n_size != '0) ? n_hand : '0;
            r_hand_vld <= (n_size != '0);
            r_count    <= n_size;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_res_status     = r_status;
    assign o_res_granted    = r_granted;
    assign o_res_hand       = r_hand_out;
    assign o_res_hand_valid = r_hand_vld;
    assign o_res_count      = r_count;

endmodule

`default_nettype wire

/* hw/rtl/page_frame_allocator_clock_list_top.sv */
// In the transfer cycle a request issues reads of the link RAMs and the
// free-frame ring; in ST_EXEC the core updates the list, writes the links back
// and loads the result register. The next request is taken only once that
// update is done, so requests never overlap; a stalled result holds the update
// of the pending request. Residency bits clear at reset, so no clearing pass
// is needed.
// The capacity write channel is always ready. Owner data is not retained.
//
// Top level of the page frame allocator; instantiates pfa_core and pfa_ram.
// Depends on pfa_pkg.
`default_nettype none

module page_frame_allocator_clock_list_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Capacity register: frame_capacity
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pfa_pkg::CAP_W-1:0]         i_cfg_data,
    // Requests
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // process_id[31:0], virtual_page[83:32], frame_number[91:84], zero[95:92]
    input  wire logic [pfa_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // operation[0]
    input  wire logic                              i_s_tuser,
    // Results
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // granted_frame[7:0], hand_frame[15:8], hand_valid[16],
    // resident_count[25:17], zero[31:26]
    output logic [pfa_pkg::M_TDATA_W-1:0]          o_m_tdata,
    // status[1:0]
    output logic [pfa_pkg::STATUS_W-1:0]           o_m_tuser
);

    import pfa_pkg::*;

    localparam int FRAME_LSB = PID_W + PAGE_W;

    t_ram_rd link_rd, ring_rd;
    t_ram_wr next_wr, prev_wr, ring_wr;
    t_frame  next_rdata, prev_rdata, ring_rdata;

    t_status res_status;
    t_frame  res_granted, res_hand;
    logic    res_hand_valid;
    t_count  res_count;

    pfa_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_req_valid      (i_s_tvalid),
        .o_req_ready      (o_s_tready),
        .i_req_op         (i_s_tuser),
        .i_req_frame      (i_s_tdata[FRAME_LSB +: FRAME_W]),
        .o_res_valid      (o_m_tvalid),
        .i_res_ready      (i_m_tready),
        .o_res_status     (res_status),
        .o_res_granted    (res_granted),
        .o_res_hand       (res_hand),
        .o_res_hand_valid (res_hand_valid),
        .o_res_count      (res_count),
        .o_link_rd        (link_rd),
        .i_next_rdata     (next_rdata),
        .i_prev_rdata     (prev_rdata),
        .o_next_wr        (next_wr),
        .o_prev_wr        (prev_wr),
        .o_ring_rd        (ring_rd),
        .i_ring_rdata     (ring_rdata),
        .o_ring_wr        (ring_wr)
    );

    // Successor links
    pfa_ram #(.ADDR_W(FRAME_W), .DATA_W(FRAME_W)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_wr.en),
        .i_waddr (next_wr.addr),
        .i_wdata (next_wr.data),
        .i_re    (link_rd.en),
        .i_raddr (link_rd.addr),
        .o_rdata (next_rdata)
    );

    // Predecessor links
    pfa_ram #(.ADDR_W(FRAME_W), .DATA_W(FRAME_W)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_wr.en),
        .i_waddr (prev_wr.addr),
        .i_wdata (prev_wr.data),
        .i_re    (link_rd.en),
        .i_raddr (link_rd.addr),
        .o_rdata (prev_rdata)
    );

    // Ring of freed frames
    pfa_ram #(.ADDR_W(FRAME_W), .DATA_W(FRAME_W)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_wr.en),
        .i_waddr (ring_wr.addr),
        .i_wdata (ring_wr.data),
        .i_re    (ring_rd.en),
        .i_raddr (ring_rd.addr),
        .o_rdata (ring_rdata)
    );

    // Pack the result transfer
    assign o_m_tdata = {
        (M_TDATA_W - (3 * FRAME_W + 2))'(0),
        res_count,
        res_hand_valid,
        res_hand,
        res_granted
    };
    assign o_m_tuser = res_status;

endmodule

`default_nettype wire

/* sim/pfa_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the page frame allocator: watches the capacity, request and
// result channels, predicts each result and compares it field by field.
// Depends on pfa_pkg for widths, codes and the request kind.
module pfa_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pfa_pkg::CAP_W-1:0]      i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // process_id[31:0], virtual_page[83:32], frame_number[91:84], zero[95:92]
    input  logic [pfa_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // operation[0]
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // granted_frame[7:0], hand_frame[15:8], hand_valid[16],
    // resident_count[25:17], zero[31:26]
    input  logic [pfa_pkg::M_TDATA_W-1:0]  i_m_tdata,
    // status[1:0]
    input  logic [pfa_pkg::STATUS_W-1:0]   i_m_tuser,
    output int                             o_errors,
    output int                             o_outstanding,
    output int                             o_results,
    output int                             o_full_seen,
    output int                             o_not_resident_seen,
    output logic [pfa_pkg::MAX_FRAMES-1:0] o_resident
);

    import pfa_pkg::*;

    typedef struct packed {
        t_status status;
        t_frame  granted;
        t_frame  hand;
        logic    hand_valid;
        t_count  count;
    } t_alloc_result;

    t_alloc_result grant_q[$];
    t_alloc_result want_r, seen_r;

    // Allocator shadow state
    t_frame               succ_link [MAX_FRAMES];
    t_frame               pred_link [MAX_FRAMES];
    bit                   has_pred  [MAX_FRAMES];
    bit                   has_succ  [MAX_FRAMES];
    bit [MAX_FRAMES-1:0]  resident;
    t_frame               freed_ring [MAX_FRAMES];
    t_frame               ring_rd, ring_wr;
    t_count               ring_cnt, bump, list_len;
    t_frame               head, tail, hand;
    logic [CAP_W-1:0]     capacity;

    task automatic note_failure(input string msg);
        if (o_errors < 10)
            $display("%0t: MISMATCH %s", $realtime, msg);
        o_errors++;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned seen);
        if (want !== seen)
            note_failure($sformatf("%s expected %0d, got %0d", name, want, seen));
    endtask

    // Append a frame at the tail; the hand lands on it if the list was empty
    task automatic append_frame(input t_frame f);
        has_pred[f]  = 1'b0;
        has_succ[f]  = 1'b0;
        succ_link[f] = '0;
        pred_link[f] = '0;
        if (list_len != 0) begin
            succ_link[tail] = f;
            has_succ[tail]  = 1'b1;
            pred_link[f]    = tail;
            has_pred[f]     = 1'b1;
        end else begin
            head = f;
            hand = f;
        end
        tail = f;
        list_len++;
    endtask

    // Unlink a resident frame and advance the hand if it pointed there
    task automatic remove_frame(input t_frame f);
        t_frame p, n;
        p = pred_link[f];
        n = succ_link[f];
        if (!has_pred[f] && !has_succ[f]) begin
            head = '0;
            tail = '0;
            hand = '0;
        end else if (!has_pred[f]) begin
            if (hand == f)
                hand = n;
            head = n;
            has_pred[n] = 1'b0;
        end else if (!has_succ[f]) begin
            if (hand == f)
                hand = head;
            tail = p;
            has_succ[p] = 1'b0;
        end else begin
            if (hand == f)
                hand = n;
            succ_link[p] = n;
            pred_link[n] = p;
        end
        has_pred[f] = 1'b0;
        has_succ[f] = 1'b0;
        if (list_len != 0)
            list_len--;
    endtask

    // Apply one request to the shadow state and form the result it yields
    task automatic serve_request(input logic op, input t_frame target,
                                 output t_alloc_result r);
        t_count limit;
        t_frame f;
        bit     got;
        r        = '0;
        r.status = STATUS_OK;
        got      = 1'b0;
        f        = '0;
        if (op == OP_ALLOC) begin
            limit = (capacity < MAX_FRAMES) ? t_count'(capacity) : t_count'(MAX_FRAMES);
            if (ring_cnt != 0) begin
                f = freed_ring[ring_rd];
                ring_rd++;
                ring_cnt--;
                got = 1'b1;
            end else if (bump < limit) begin
                f = t_frame'(bump);
                bump++;
                got = 1'b1;
            end
            if (got) begin
                resident[f] = 1'b1;
                append_frame(f);
                r.granted = f;
            end else begin
                r.status = STATUS_FULL;
            end
        end else begin
            if (resident[target]) begin
                remove_frame(target);
                resident[target] = 1'b0;
                if (ring_cnt < MAX_FRAMES) begin
                    freed_ring[ring_wr] = target;
                    ring_wr++;
                    ring_cnt++;
                end
            end else begin
                r.status = STATUS_NOT_RESIDENT;
            end
        end
        r.hand_valid = (list_len != 0);
        r.hand       = r.hand_valid ? hand : '0;
        r.count      = list_len;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                succ_link[k]  = '0;
                pred_link[k]  = '0;
                has_pred[k]   = 1'b0;
                has_succ[k]   = 1'b0;
                freed_ring[k] = '0;
            end
            resident = '0;
            ring_rd  = '0;
            ring_wr  = '0;
            ring_cnt = '0;
            bump     = '0;
            list_len = '0;
            head     = '0;
            tail     = '0;
            hand     = '0;
            capacity = CAP_RESET;
            grant_q.delete();
        end else begin
            // Capacity transfer
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_data;

            // Result transfer: compare against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                seen_r.status     = i_m_tuser;
                seen_r.granted    = i_m_tdata[7:0];
                seen_r.hand       = i_m_tdata[15:8];
                seen_r.hand_valid = i_m_tdata[16];
                seen_r.count      = i_m_tdata[25:17];
                o_results++;
                if (seen_r.status == STATUS_FULL)
                    o_full_seen++;
                if (seen_r.status == STATUS_NOT_RESIDENT)
                    o_not_resident_seen++;
                if (grant_q.size() == 0) begin
                    note_failure($sformatf("result with nothing pending: tdata %h tuser %0d",
                                           i_m_tdata, i_m_tuser));
                end else begin
                    want_r = grant_q.pop_front();
                    compare_field("status", want_r.status, seen_r.status);
                    compare_field("granted_frame", want_r.granted, seen_r.granted);
                    compare_field("hand_frame", want_r.hand, seen_r.hand);
                    compare_field("hand_valid", want_r.hand_valid, seen_r.hand_valid);
                    compare_field("resident_count", want_r.count, seen_r.count);
                end
            end

            // Request transfer: predict its result
            if (i_s_tvalid && i_s_tready) begin
                serve_request(i_s_tuser, i_s_tdata[91:84], want_r);
                grant_q.push_back(want_r);
            end
        end
        o_outstanding <= grant_q.size();
        o_resident    <= resident;
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request and capacity stimulus,
// result back-pressure and the verdict. Depends on pfa_pkg and pfa_checker.
module tb;
    import pfa_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int NUM_PHASES  = 9;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    int                    errors, outstanding, results, full_seen, not_resident_seen;
    logic [MAX_FRAMES-1:0] resident_view;
    int                    cycles = 0;
    int                    requests = 0;
    int                    cap_writes = 0;

    // Random phases: capacity, allocate share in percent, request count
    int phase_cap   [NUM_PHASES] = '{256, 256, 16, 511, 2, 255, 40, 1, 300};
    int phase_alloc [NUM_PHASES] = '{90, 40, 55, 60, 50, 35, 50, 50, 70};
    int phase_len   [NUM_PHASES] = '{320, 200, 150, 200, 100, 200, 150, 60, 120};

    page_frame_allocator_clock_list_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    pfa_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_data          (cfg_data),
        .i_s_tvalid          (s_tvalid),
        .i_s_tready          (s_tready),
        .i_s_tdata           (s_tdata),
        .i_s_tuser           (s_tuser),
        .i_m_tvalid          (m_tvalid),
        .i_m_tready          (m_tready),
        .i_m_tdata           (m_tdata),
        .i_m_tuser           (m_tuser),
        .o_errors            (errors),
        .o_outstanding       (outstanding),
        .o_results           (results),
        .o_full_seen         (full_seen),
        .o_not_resident_seen (not_resident_seen),
        .o_resident          (resident_view)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
            $display("tb NOT OK");
            $finish;
        end
    end

    // Stretches of back-to-back traffic between the randomly gapped ones
    function automatic bit quiet_window(input int n);
        return ((n / 40) % 4) == 3;
    endfunction

    // Pick a frame the allocator currently holds, or -1 if none
    function automatic int pick_resident();
        int start;
        start = $urandom_range(0, MAX_FRAMES - 1);
        for (int k = 0; k < MAX_FRAMES; k++)
            if (resident_view[(start + k) % MAX_FRAMES])
                return (start + k) % MAX_FRAMES;
        return -1;
    endfunction

    // Result sink: stall a random number of cycles before each transfer
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = quiet_window(taken) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            taken++;
        end
    end

    // Send one request after a random gap; return at its transfer
    task automatic issue_request(input logic op, input logic [PID_W-1:0] pid,
                                 input logic [PAGE_W-1:0] page, input t_frame frame);
        int gap;
        gap = quiet_window(requests) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, frame, page, pid};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        requests++;
    endtask

    task automatic alloc_random();
        issue_request(OP_ALLOC, $urandom(), PAGE_W'({$urandom(), $urandom()}),
                      t_frame'($urandom_range(0, MAX_FRAMES - 1)));
    endtask

    task automatic free_frame(input t_frame frame);
        issue_request(OP_FREE, $urandom(), PAGE_W'({$urandom(), $urandom()}), frame);
    endtask

    // Drain all results, let the block settle, then write the capacity
    task automatic set_capacity(input int cap);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CAP_W'(cap);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    initial begin
        int pick;
        t_frame frame;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, extreme owner fields, head, tail, middle frees
        set_capacity(256);
        free_frame(8'd0);
        issue_request(OP_ALLOC, '1, '1, 8'hFF);
        issue_request(OP_ALLOC, '0, '0, 8'h00);
        repeat (3) alloc_random();
        free_frame(8'd0);
        free_frame(8'd4);
        free_frame(8'd2);
        free_frame(8'd2);
        free_frame(8'd255);
        alloc_random();
        free_frame(8'd1);
        free_frame(8'd3);
        free_frame(8'd0);

        // Capacity below frames already handed out: only reuse, then full
        set_capacity(1);
        repeat (6) alloc_random();
        // Capacity zero: freed frames only
        set_capacity(0);
        free_frame(8'd4);
        repeat (2) alloc_random();

        // Random phases over a range of capacities
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_capacity(phase_cap[p]);
            for (int i = 0; i < phase_len[p]; i++) begin
                if ($urandom_range(0, 99) < phase_alloc[p]) begin
                    alloc_random();
                end else begin
                    pick = pick_resident();
                    if (pick < 0 || $urandom_range(0, 9) < 3)
                        frame = t_frame'($urandom_range(0, MAX_FRAMES - 1));
                    else
                        frame = t_frame'(pick);
                    free_frame(frame);
                end
            end
        end

        // Wait out the last results
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d requests across %0d capacity writes (0, 1, 256 and 511 included)",
                 requests, cap_writes);
        $display("Checked %0d results: %0d full, %0d frees of non-resident frames",
                 results, full_seen, not_resident_seen);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
